// ===== src/saa_pkg.sv =====
// ----------------------------------------------------------------------------
// saa_pkg
// shared types and constants of the shelf atlas allocator
// ----------------------------------------------------------------------------
`default_nettype none

package saa_pkg;

   // atlas geometry
   localparam int PAGE_SIZE = 512;
   localparam int MAX_PAGES = 8;
   localparam int PAD       = 1;

   // fixed widths of the transaction fields
   localparam int RECT_W   = 10;
   localparam int STATUS_W = 3;
   localparam int PAGE_W   = 3;
   localparam int POS_W    = 9;

   // derived widths
   localparam int COORD_W    = $clog2(PAGE_SIZE + 1);
   localparam int PADDED_W   = RECT_W + 1;
   localparam int SUM_W      = ((COORD_W > PADDED_W) ? COORD_W : PADDED_W) + 1;
   localparam int PAGE_IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PAGES_W    = $clog2(MAX_PAGES + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PLACED   = 3'd0,
      STATUS_EMPTY    = 3'd1,
      STATUS_OVERSIZE = 3'd2,
      STATUS_NO_SPACE = 3'd3,
      STATUS_CLEARED  = 3'd4
   } status_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

endpackage : saa_pkg

`default_nettype wire

// ===== src/shelf_atlas_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// shelf_atlas_allocator_unit
// shelf packing allocator for square atlas pages
// ----------------------------------------------------------------------------
// usage
//  - request channel: req_kind, req_rect_width, req_rect_height; a transaction
//    is taken at a rising edge with start high and busy low
//  - response channel: one transaction per request, shown on the rsp_ ports
//    for exactly one cycle while rsp_valid is high; the receiver cannot stall
//  - a clear, an empty size or an oversize request answers in the cycle
//    after it is taken
//  - an allocate walks the open pages one per cycle through a single shared
//    fit/wrap unit; the walk stops at the first page that takes the box
//  - busy drops in the cycle after the response
//  - a page visited and wrapped to a new shelf keeps that wrap even when the
//    rectangle fails there
//  - reset (synchronous) empties all pages at once, as does a clear request
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_atlas_allocator_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_kind,
   input  wire logic [saa_pkg::RECT_W-1:0]   req_rect_width,
   input  wire logic [saa_pkg::RECT_W-1:0]   req_rect_height,
   output logic                              rsp_valid,
   output logic [saa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [saa_pkg::PAGE_W-1:0]        rsp_page_index,
   output logic [saa_pkg::POS_W-1:0]         rsp_pos_x,
   output logic [saa_pkg::POS_W-1:0]         rsp_pos_y,
   output logic                              rsp_opened_page
);
   import saa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // sequencer
   state_type             state_ff, state_in;
   logic [PAGES_W-1:0]    scan_cnt_ff, scan_cnt_in;

   // latched padded request size
   logic [PADDED_W-1:0]   pw_ff, pw_in;
   logic [PADDED_W-1:0]   ph_ff, ph_in;

   // per-page shelf state
   logic [COORD_W-1:0]    pen_x_ff [MAX_PAGES];
   logic [COORD_W-1:0]    pen_x_in [MAX_PAGES];
   logic [COORD_W-1:0]    pen_y_ff [MAX_PAGES];
   logic [COORD_W-1:0]    pen_y_in [MAX_PAGES];
   logic [COORD_W-1:0]    row_h_ff [MAX_PAGES];
   logic [COORD_W-1:0]    row_h_in [MAX_PAGES];
   logic [PAGES_W-1:0]    pages_ff, pages_in;

   // response registers
   logic                  valid_ff, valid_in;
   status_type            status_ff, status_in;
   logic [PAGE_IDX_W-1:0] page_ff, page_in;
   logic [COORD_W-1:0]    x_ff, x_in;
   logic [COORD_W-1:0]    y_ff, y_in;
   logic                  opened_ff, opened_in;

   // shared page visit unit
   logic [PAGE_IDX_W-1:0] vis_idx;
   logic [COORD_W-1:0]    vis_pen_x;
   logic [COORD_W-1:0]    vis_pen_y;
   logic [COORD_W-1:0]    vis_row_h;
   logic                  vis_wrap;
   logic [COORD_W-1:0]    cur_x;
   logic [COORD_W-1:0]    cur_y;
   logic [COORD_W-1:0]    cur_h;
   logic                  vis_fit;
   logic [COORD_W-1:0]    ph_coord;
   logic [COORD_W-1:0]    pw_coord;

   // request decode
   logic [PADDED_W-1:0]   req_pw;
   logic [PADDED_W-1:0]   req_ph;
   logic                  req_empty;
   logic                  req_oversize;

   assign req_pw       = {1'b0, req_rect_width} + PADDED_W'(PAD);
   assign req_ph       = {1'b0, req_rect_height} + PADDED_W'(PAD);
   assign req_empty    = (req_rect_width == '0) || (req_rect_height == '0);
   assign req_oversize = (req_pw > PADDED_W'(PAGE_SIZE)) || (req_ph > PADDED_W'(PAGE_SIZE));

   // padded sizes fit the coordinate width once the oversize check passed
   assign pw_coord = COORD_W'(pw_ff);
   assign ph_coord = COORD_W'(ph_ff);

   assign vis_idx   = scan_cnt_ff[PAGE_IDX_W-1:0];
   assign vis_pen_x = pen_x_ff[vis_idx];
   assign vis_pen_y = pen_y_ff[vis_idx];
   assign vis_row_h = row_h_ff[vis_idx];

   // wrap to a new shelf when the padded width overruns the row
   assign vis_wrap = (SUM_W'(vis_pen_x) + SUM_W'(pw_ff)) > SUM_W'(PAGE_SIZE);
   assign cur_x    = vis_wrap ? '0 : vis_pen_x;
   assign cur_y    = vis_wrap ? COORD_W'(vis_pen_y + vis_row_h) : vis_pen_y;
   assign cur_h    = vis_wrap ? '0 : vis_row_h;
   assign vis_fit  = (SUM_W'(cur_y) + SUM_W'(ph_ff)) <= SUM_W'(PAGE_SIZE);

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      pw_in       = pw_ff;
      ph_in       = ph_ff;
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      row_h_in    = row_h_ff;
      pages_in    = pages_ff;
      valid_in    = 1'b0;
      status_in   = status_ff;
      page_in     = page_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      opened_in   = opened_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pw_in       = req_pw;
               ph_in       = req_ph;
               scan_cnt_in = '0;
               page_in     = '0;
               x_in        = '0;
               y_in        = '0;
               opened_in   = 1'b0;
               priority if (req_kind == KIND_CLEAR) begin
                  // empty every page at once
                  for (int p = 0; p < MAX_PAGES; p++) begin
                     pen_x_in[p] = '0;
                     pen_y_in[p] = '0;
                     row_h_in[p] = '0;
                  end
                  pages_in  = '0;
                  status_in = STATUS_CLEARED;
                  valid_in  = 1'b1;
                  state_in  = ST_RESP;
               end else if (req_empty) begin
                  status_in = STATUS_EMPTY;
                  valid_in  = 1'b1;
                  state_in  = ST_RESP;
               end else if (req_oversize) begin
                  status_in = STATUS_OVERSIZE;
                  valid_in  = 1'b1;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == pages_ff) begin
               // no open page took it: open a new page or give up
               if (pages_ff == PAGES_W'(MAX_PAGES)) begin
                  status_in = STATUS_NO_SPACE;
               end else begin
                  pen_x_in[pages_ff[PAGE_IDX_W-1:0]] = pw_coord;
                  pen_y_in[pages_ff[PAGE_IDX_W-1:0]] = '0;
                  row_h_in[pages_ff[PAGE_IDX_W-1:0]] = ph_coord;
                  pages_in  = pages_ff + PAGES_W'(1);
                  status_in = STATUS_PLACED;
                  page_in   = pages_ff[PAGE_IDX_W-1:0];
                  opened_in = 1'b1;
               end
               valid_in = 1'b1;
               state_in = ST_RESP;
            end else begin
               // wrap is written back even when the height fails
               pen_x_in[vis_idx] = vis_fit ? COORD_W'(cur_x + pw_coord) : cur_x;
               pen_y_in[vis_idx] = cur_y;
               row_h_in[vis_idx] = (vis_fit && (ph_coord > cur_h)) ? ph_coord : cur_h;
               if (vis_fit) begin
                  status_in = STATUS_PLACED;
                  page_in   = vis_idx;
                  x_in      = cur_x;
                  y_in      = cur_y;
                  valid_in  = 1'b1;
                  state_in  = ST_RESP;
               end else begin
                  scan_cnt_in = scan_cnt_ff + PAGES_W'(1);
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         pages_ff <= '0;
         for (int p = 0; p < MAX_PAGES; p++) begin
            pen_x_ff[p] <= '0;
            pen_y_ff[p] <= '0;
            row_h_ff[p] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pages_ff <= pages_in;
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         row_h_ff <= row_h_in;
      end
      scan_cnt_ff <= scan_cnt_in;
      pw_ff       <= pw_in;
      ph_ff       <= ph_in;
      status_ff   <= status_in;
      page_ff     <= page_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      opened_ff   <= opened_in;
   end

   // outputs
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_page_index  = PAGE_W'(page_ff);
   assign rsp_pos_x       = x_ff[POS_W-1:0];
   assign rsp_pos_y       = y_ff[POS_W-1:0];
   assign rsp_opened_page = opened_ff;

endmodule : shelf_atlas_allocator_unit

`default_nettype wire
